[sv/ptts_pkg.sv]
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

   // Slot table geometry (slot number is the task priority)
   localparam int NUM_SLOTS  = 8;
   localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W      = IDX_W + 1;

   // Field widths
   localparam int OPCODE_W   = 3;
   localparam int TASK_W     = 8;
   localparam int PERIOD_W   = 16;
   localparam int DELAY_W    = 8;
   localparam int FIRED_IDX_W = 6;
   localparam int WORD_W     = 2 * PERIOD_W;

   // At most this many due tasks are reported per tick
   localparam int RESULT_CAP = 8;
   localparam int REP_W      = $clog2(RESULT_CAP + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK     = 3'd0,
      OP_CREATE   = 3'd1,
      OP_DELETE   = 3'd2,
      OP_ACTIVATE = 3'd3,
      OP_SUSPEND  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_REJECT       = 2'd1,
      ST_NULL_HANDLER = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMD,
      S_WALK,
      S_FLUSH
   } state_type;

   typedef struct packed {
      status_type             status;
      logic                   fired;
      logic [FIRED_IDX_W-1:0] fired_index;
      logic                   last;
   } rsp_item_type;

endpackage

`default_nettype wire

[sv/periodic_task_tick_scheduler_core.sv]
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core
// Time-triggered cooperative scheduler: slot table with tick walk.
// ----------------------------------------------------------------------------
// Commands (create, delete, activate, suspend) take one input transfer and
// give one result: the slot is read from RAM, then the result goes to the
// output register once it is free. A tick reads the period/countdown RAM
// one slot per cycle while the result side does not stall. Each due task
// is reported as one result with the slot number (at most eight per tick,
// last one flagged by tlast); a tick with nothing due reports one result
// with fired low. Only one input item is in work at a time.
`default_nettype none

module periodic_task_tick_scheduler_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] task_index, [23:8] period, [31:24] first_delay, [32] handler_given
   input  wire logic [39:0] req_tdata,
   input  wire logic [2:0]  req_tuser,   // [2:0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [1:0] status, [7:2] fired_index
   output logic             rsp_tuser,   // [0] fired
   output logic             rsp_tlast
);
   import ptts_pkg::*;

   // Input field view
   logic [TASK_W-1:0]   req_task_index;
   logic [PERIOD_W-1:0] req_period;
   logic [DELAY_W-1:0]  req_first_delay;
   logic                req_handler;

   assign req_task_index  = req_tdata[7:0];
   assign req_period      = req_tdata[23:8];
   assign req_first_delay = req_tdata[31:24];
   assign req_handler     = req_tdata[32];

   // Control and slot flags
   state_type           state_ff, state_in;
   logic [OPCODE_W-1:0] cmd_op_ff, cmd_op_in;
   logic [TASK_W-1:0]   cmd_idx_ff, cmd_idx_in;
   logic [PERIOD_W-1:0] cmd_per_ff, cmd_per_in;
   logic [DELAY_W-1:0]  cmd_dly_ff, cmd_dly_in;
   logic                cmd_hnd_ff, cmd_hnd_in;
   logic [NUM_SLOTS-1:0] occ_ff, occ_in;
   logic [NUM_SLOTS-1:0] act_ff, act_in;
   logic [NUM_SLOTS-1:0] wok_ff, wok_in;
   logic [CNT_W-1:0]    rd_cnt_ff, rd_cnt_in;
   logic [IDX_W-1:0]    p1_idx_ff, p1_idx_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [REP_W-1:0]    rep_cnt_ff, rep_cnt_in;

   // RAM port signals
   logic              ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0] ram_wr_data, ram_rd_data;

   // Result side
   logic         rsp_load;
   logic         out_free;
   rsp_item_type rsp_item;

   // Working values
   logic [IDX_W-1:0]    slot_sel;
   logic [WORD_W-1:0]   slot_word;
   logic [PERIOD_W-1:0] slot_period, slot_cd;
   logic                cmd_in_range, cmd_slot_ok;
   status_type          cmd_status;
   logic                walk_act, walk_fire, walk_report, walk_push, walk_stall;

   ptts_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ptts_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (rsp_load),
      .item       (rsp_item),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Read data of the slot under work; never-written entries read as zero
   assign slot_sel    = (state_ff == S_CMD) ? cmd_idx_ff[IDX_W-1:0] : p1_idx_ff;
   assign slot_word   = wok_ff[slot_sel] ? ram_rd_data : '0;
   assign slot_period = slot_word[WORD_W-1:PERIOD_W];
   assign slot_cd     = slot_word[PERIOD_W-1:0];

   // Command checks
   assign cmd_in_range = cmd_idx_ff < TASK_W'(NUM_SLOTS);
   assign cmd_slot_ok  = cmd_in_range && occ_ff[slot_sel];

   always_comb begin
      case (cmd_op_ff)
         OP_CREATE: begin
            if (!cmd_hnd_ff) begin
               cmd_status = ST_NULL_HANDLER;
            end else if (!cmd_in_range || occ_ff[slot_sel]) begin
               cmd_status = ST_REJECT;
            end else begin
               cmd_status = ST_OK;
            end
         end
         OP_DELETE, OP_ACTIVATE, OP_SUSPEND: begin
            cmd_status = cmd_slot_ok ? ST_OK : ST_REJECT;
         end
         default: begin
            cmd_status = ST_REJECT;
         end
      endcase
   end

   // Tick walk: decide fire/decrement for the slot whose data is back
   assign walk_act    = act_ff[p1_idx_ff];
   assign walk_fire   = walk_act && (slot_cd == '0);
   assign walk_report = walk_fire && (rep_cnt_ff < REP_W'(RESULT_CAP));
   assign walk_push   = walk_report && pend_valid_ff;
   assign walk_stall  = walk_push && !out_free;

   // Next state, RAM access and result generation
   always_comb begin
      state_in      = state_ff;
      cmd_op_in     = cmd_op_ff;
      cmd_idx_in    = cmd_idx_ff;
      cmd_per_in    = cmd_per_ff;
      cmd_dly_in    = cmd_dly_ff;
      cmd_hnd_in    = cmd_hnd_ff;
      occ_in        = occ_ff;
      act_in        = act_ff;
      wok_in        = wok_ff;
      rd_cnt_in     = rd_cnt_ff;
      p1_idx_in     = p1_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rep_cnt_in    = rep_cnt_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_sel;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      rsp_load      = 1'b0;
      rsp_item      = '{status: ST_OK, fired: 1'b0, fired_index: '0, last: 1'b1};
      req_tready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_op_in  = req_tuser;
               cmd_idx_in = req_task_index;
               cmd_per_in = req_period;
               cmd_dly_in = req_first_delay;
               cmd_hnd_in = req_handler;
               if (req_tuser == OP_TICK) begin
                  // Start the walk with a read of slot zero
                  ram_rd_en     = 1'b1;
                  ram_rd_addr   = '0;
                  p1_idx_in     = '0;
                  rd_cnt_in     = CNT_W'(1);
                  pend_valid_in = 1'b0;
                  rep_cnt_in    = '0;
                  state_in      = S_WALK;
               end else begin
                  // Fetch the addressed slot for read-modify-write
                  ram_rd_en   = req_task_index < TASK_W'(NUM_SLOTS);
                  ram_rd_addr = req_task_index[IDX_W-1:0];
                  state_in    = S_CMD;
               end
            end
         end

         S_CMD: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_item.status = cmd_status;
               state_in        = S_IDLE;
               if (cmd_status == ST_OK) begin
                  case (cmd_op_ff)
                     OP_CREATE: begin
                        occ_in[slot_sel] = 1'b1;
                        act_in[slot_sel] = 1'b0;
                        wok_in[slot_sel] = 1'b1;
                        ram_wr_en        = 1'b1;
                        ram_wr_data      = {cmd_per_ff, {(PERIOD_W-DELAY_W){1'b0}}, cmd_dly_ff};
                     end
                     OP_DELETE: begin
                        // Clear period, keep countdown
                        occ_in[slot_sel] = 1'b0;
                        act_in[slot_sel] = 1'b0;
                        wok_in[slot_sel] = 1'b1;
                        ram_wr_en        = 1'b1;
                        ram_wr_data      = {{PERIOD_W{1'b0}}, slot_cd};
                     end
                     OP_ACTIVATE: begin
                        act_in[slot_sel] = 1'b1;
                     end
                     OP_SUSPEND: begin
                        act_in[slot_sel] = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         S_WALK: begin
            if (!walk_stall) begin
               // Reload or count down the active slot
               if (walk_act) begin
                  ram_wr_en           = 1'b1;
                  ram_wr_addr         = p1_idx_ff;
                  ram_wr_data         = {slot_period,
                                         walk_fire ? slot_period : slot_cd - PERIOD_W'(1)};
                  wok_in[p1_idx_ff]   = 1'b1;
               end
               // Release the held due task, hold the new one
               if (walk_push) begin
                  rsp_load             = 1'b1;
                  rsp_item.fired       = 1'b1;
                  rsp_item.fired_index = FIRED_IDX_W'(pend_idx_ff);
                  rsp_item.last        = 1'b0;
               end
               if (walk_report) begin
                  pend_valid_in = 1'b1;
                  pend_idx_in   = p1_idx_ff;
                  rep_cnt_in    = rep_cnt_ff + REP_W'(1);
               end
               // Advance to the next slot or finish
               if (rd_cnt_ff < CNT_W'(NUM_SLOTS)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = rd_cnt_ff[IDX_W-1:0];
                  p1_idx_in   = rd_cnt_ff[IDX_W-1:0];
                  rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               end else begin
                  state_in = S_FLUSH;
               end
            end
         end

         S_FLUSH: begin
            // Emit the held due task as final, or the none-fired result
            if (out_free) begin
               rsp_load = 1'b1;
               if (pend_valid_ff) begin
                  rsp_item.fired       = 1'b1;
                  rsp_item.fired_index = FIRED_IDX_W'(pend_idx_ff);
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and slot flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         act_ff        <= '0;
         wok_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rep_cnt_ff    <= '0;
         rd_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         act_ff        <= act_in;
         wok_ff        <= wok_in;
         pend_valid_ff <= pend_valid_in;
         rep_cnt_ff    <= rep_cnt_in;
         rd_cnt_ff     <= rd_cnt_in;
      end
   end

   // Command and walk payload
   always_ff @(posedge clock) begin
      cmd_op_ff   <= cmd_op_in;
      cmd_idx_ff  <= cmd_idx_in;
      cmd_per_ff  <= cmd_per_in;
      cmd_dly_ff  <= cmd_dly_in;
      cmd_hnd_ff  <= cmd_hnd_in;
      p1_idx_ff   <= p1_idx_in;
      pend_idx_ff <= pend_idx_in;
   end

endmodule

`default_nettype wire

[sv/ptts_ram.sv]
// ----------------------------------------------------------------------------
// ptts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, hold data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/ptts_rsp_reg.sv]
// ----------------------------------------------------------------------------
// ptts_rsp_reg
// Output register of the result stream; takes a new item when empty or
// when the current one transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_rsp_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire ptts_pkg::rsp_item_type item,
   output logic                       out_free,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,  // [1:0] status, [7:2] fired_index
   output logic                       rsp_tuser,  // [0] fired
   output logic                       rsp_tlast
);
   import ptts_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign out_free = !valid_ff || rsp_tready;

   // Valid flag: set on load, clear once transferred
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {item_ff.fired_index, item_ff.status};
   assign rsp_tuser  = item_ff.fired;
   assign rsp_tlast  = item_ff.last;

endmodule

`default_nettype wire

[dv/tb_periodic_task_tick_scheduler_core.sv]
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler_core
// Self-checking bench for the periodic task tick scheduler core.
// ----------------------------------------------------------------------------
// Commands and ticks are sent on the request stream. A slot-table model
// inside the bench predicts each result and a monitor compares every
// response transfer against the oldest prediction. Directed tests cover
// the error paths, undefined opcodes and a tick where all slots fire. A
// random phase then runs mostly well-formed create/activate/tick traffic
// with noise mixed in. Both stream sides stall at random.
`default_nettype none

module tb_periodic_task_tick_scheduler_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ptts_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 360;
   localparam int CALM_ITEMS    = 120;
   localparam int MAX_REPORTS   = 10;
   localparam logic [OPCODE_W-1:0] OP_UNDEF_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_UNDEF_LAST  = 3'd7;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [TASK_W-1:0]   task_index;
      logic [PERIOD_W-1:0] period;
      logic [DELAY_W-1:0]  first_delay;
      logic                handler_given;
   } sched_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // Slot table copy used for prediction
   logic                slot_used [NUM_SLOTS];
   logic                slot_running [NUM_SLOTS];
   logic [PERIOD_W-1:0] slot_reload [NUM_SLOTS];
   logic [PERIOD_W-1:0] slot_count [NUM_SLOTS];

   rsp_item_type expected_rsp [$];

   int idle_pct = 21;
   int failures = 0;
   int items_sent = 0;
   int results_seen = 0;
   int fires_seen = 0;
   int cycle_count = 0;

   periodic_task_tick_scheduler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rsp.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("[%0t] FAIL: %s", $realtime, msg);
   endtask

   function automatic sched_cmd_type make_cmd(input logic [OPCODE_W-1:0] op,
                                              input int idx, input int per,
                                              input int dly, input logic hnd);
      sched_cmd_type c;
      c.opcode        = op;
      c.task_index    = TASK_W'(idx);
      c.period        = PERIOD_W'(per);
      c.first_delay   = DELAY_W'(dly);
      c.handler_given = hnd;
      return c;
   endfunction

   // Advance the slot table by one command and queue the results it causes
   task automatic schedule_results(input sched_cmd_type c);
      rsp_item_type r;
      int           due [$];
      bit           in_use;
      int           idx;
      idx    = int'(c.task_index);
      in_use = (idx < NUM_SLOTS) && slot_used[idx];
      r      = '{status: ST_OK, fired: 1'b0, fired_index: '0, last: 1'b1};
      case (c.opcode)
         OP_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_running[i]) begin
                  if (slot_count[i] == '0) begin
                     slot_count[i] = slot_reload[i];
                     if (due.size() < RESULT_CAP)
                        due.push_back(i);
                  end else begin
                     slot_count[i] = slot_count[i] - 1'b1;
                  end
               end
            end
         end
         OP_CREATE: begin
            if (!c.handler_given) begin
               r.status = ST_NULL_HANDLER;
            end else if (idx >= NUM_SLOTS || slot_used[idx]) begin
               r.status = ST_REJECT;
            end else begin
               slot_used[idx]    = 1'b1;
               slot_running[idx] = 1'b0;
               slot_reload[idx]  = c.period;
               slot_count[idx]   = PERIOD_W'(c.first_delay);
            end
         end
         OP_DELETE: begin
            if (!in_use) begin
               r.status = ST_REJECT;
            end else begin
               slot_used[idx]    = 1'b0;
               slot_running[idx] = 1'b0;
               slot_reload[idx]  = '0;
            end
         end
         OP_ACTIVATE: begin
            if (!in_use) r.status = ST_REJECT;
            else         slot_running[idx] = 1'b1;
         end
         OP_SUSPEND: begin
            if (!in_use) r.status = ST_REJECT;
            else         slot_running[idx] = 1'b0;
         end
         default: r.status = ST_REJECT;
      endcase
      if (due.size() == 0) begin
         expected_rsp.push_back(r);
      end else begin
         foreach (due[k]) begin
            r.fired       = 1'b1;
            r.fired_index = FIRED_IDX_W'(due[k]);
            r.last        = (k == due.size() - 1);
            expected_rsp.push_back(r);
         end
      end
   endtask

   // Drive one request transfer, then predict its results
   task automatic send_cmd(input sched_cmd_type c);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.opcode;
      req_tdata  <= {7'd0, c.handler_given, c.first_delay, c.period, c.task_index};
      do @(posedge clock); while (!req_tready);
      schedule_results(c);
      items_sent++;
   endtask

   // Drop valid and hold until every predicted result has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // Response monitor and random back-pressure
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = status_type'(rsp_tdata[1:0]);
         got.fired_index = rsp_tdata[7:2];
         got.fired       = rsp_tuser;
         got.last        = rsp_tlast;
         results_seen++;
         if (got.fired) fires_seen++;
         if (expected_rsp.size() == 0) begin
            note_failure($sformatf("unexpected result status=%0d fired=%0b idx=%0d last=%0b",
                                   got.status, got.fired, got.fired_index, got.last));
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.fired !== want.fired ||
                got.fired_index !== want.fired_index || got.last !== want.last)
               note_failure($sformatf(
                  {"result %0d: expected status=%0d fired=%0b idx=%0d last=%0b, ",
                   "got status=%0d fired=%0b idx=%0d last=%0b"},
                  results_seen, want.status, want.fired, want.fired_index, want.last,
                  got.status, got.fired, got.fired_index, got.last));
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
   end

   // Tick on an empty table
   task automatic test_empty_tick();
      send_cmd(make_cmd(OP_TICK, 0, 0, 0, 1'b0));
      wait_for_results();
   endtask

   // Null handler, bad index, occupied slot, unused slot, undefined opcodes
   task automatic test_command_errors();
      send_cmd(make_cmd(OP_CREATE, 255, 16'hFFFF, 8'hFF, 1'b0));
      send_cmd(make_cmd(OP_CREATE, NUM_SLOTS, 5, 5, 1'b1));
      send_cmd(make_cmd(OP_CREATE, 0, 0, 0, 1'b1));
      send_cmd(make_cmd(OP_CREATE, 0, 3, 3, 1'b1));
      send_cmd(make_cmd(OP_DELETE, 5, 0, 0, 1'b1));
      send_cmd(make_cmd(OP_ACTIVATE, 200, 0, 0, 1'b1));
      send_cmd(make_cmd(OP_SUSPEND, 6, 0, 0, 1'b1));
      send_cmd(make_cmd(OP_UNDEF_FIRST, 1, 16'hFFFF, 8'hFF, 1'b1));
      send_cmd(make_cmd(OP_UNDEF_LAST, 255, 16'hFFFF, 8'hFF, 1'b1));
      wait_for_results();
   endtask

   // Every slot due on the same tick: longest result burst
   task automatic test_all_slots_fire();
      for (int i = 1; i < NUM_SLOTS; i++)
         send_cmd(make_cmd(OP_CREATE, i, (i == NUM_SLOTS - 1) ? 16'hFFFF : i % 3, 0, 1'b1));
      for (int i = 0; i < NUM_SLOTS; i++)
         send_cmd(make_cmd(OP_ACTIVATE, i, 0, 0, 1'b1));
      send_cmd(make_cmd(OP_TICK, 0, 0, 0, 1'b1));
      wait_for_results();
   endtask

   // Suspend and delete take slots out of the walk
   task automatic test_suspend_delete();
      send_cmd(make_cmd(OP_SUSPEND, 3, 0, 0, 1'b1));
      send_cmd(make_cmd(OP_DELETE, NUM_SLOTS - 1, 0, 0, 1'b1));
      send_cmd(make_cmd(OP_TICK, 0, 0, 0, 1'b1));
      wait_for_results();
   endtask

   // Weighted random traffic, mostly sane slot usage with noise
   task automatic test_random_traffic();
      sched_cmd_type c;
      int            pick;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_pct = (n < CALM_ITEMS) ? 0 : 21;
         pick = $urandom_range(0, 99);
         c = make_cmd(OP_TICK, $urandom_range(0, NUM_SLOTS - 1), 0, 0, 1'b1);
         if (pick < 35) begin
            c.opcode = OP_TICK;
         end else if (pick < 55) begin
            c.opcode = OP_CREATE;
            if ($urandom_range(0, 9) == 0) c.task_index = TASK_W'($urandom);
            c.handler_given = ($urandom_range(0, 19) != 0);
            c.period = ($urandom_range(0, 6) != 0) ? PERIOD_W'($urandom_range(0, 7))
                                                    : PERIOD_W'($urandom);
            c.first_delay = ($urandom_range(0, 6) != 0) ? DELAY_W'($urandom_range(0, 7))
                                                         : DELAY_W'($urandom);
         end else if (pick < 70) begin
            c.opcode = OP_ACTIVATE;
         end else if (pick < 78) begin
            c.opcode = OP_SUSPEND;
         end else if (pick < 86) begin
            c.opcode = OP_DELETE;
         end else begin
            // Noise: any opcode with every field random
            c.opcode = (pick < 94) ? OPCODE_W'($urandom)
                                   : OPCODE_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
            c.task_index    = TASK_W'($urandom);
            c.period        = PERIOD_W'($urandom);
            c.first_delay   = DELAY_W'($urandom);
            c.handler_given = 1'($urandom);
         end
         send_cmd(c);
      end
      idle_pct = 21;
      wait_for_results();
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_used[i]    = 1'b0;
         slot_running[i] = 1'b0;
         slot_reload[i]  = '0;
         slot_count[i]   = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_tick();
      test_command_errors();
      test_all_slots_fire();
      test_suspend_delete();
      test_random_traffic();

      // Let any stray output show up before the verdict
      repeat (4 * NUM_SLOTS) @(posedge clock);
      if (expected_rsp.size() != 0)
         note_failure($sformatf("%0d results never arrived", expected_rsp.size()));

      $display("Sent %0d commands and ticks; checked %0d results, %0d of them task fires.",
               items_sent, results_seen, fires_seen);
      $display("Failures: %0d", failures);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
